### hw/rtl/smcs_pkg.sv
package smcs_pkg;

    localparam int COLUMNS_DEF = 8;
    localparam int ROWS_DEF    = 16;

    localparam logic [7:0] BEAT_LIMIT_RESET = 8'd48;

    localparam logic [3:0] FUNC_TICK        = 4'd0;
    localparam logic [3:0] FUNC_WRITE_COL   = 4'd1;
    localparam logic [3:0] FUNC_OPEN_SHOW   = 4'd2;
    localparam logic [3:0] FUNC_OPEN_SINGLE = 4'd3;
    localparam logic [3:0] FUNC_OPEN_LEVELS = 4'd4;
    localparam logic [3:0] FUNC_UP          = 4'd5;
    localparam logic [3:0] FUNC_DOWN        = 4'd6;
    localparam logic [3:0] FUNC_ENTER       = 4'd7;
    localparam logic [3:0] FUNC_EXIT        = 4'd8;

    localparam logic [1:0] MODE_INACTIVE = 2'd0;
    localparam logic [1:0] MODE_VIEW     = 2'd1;
    localparam logic [1:0] MODE_SINGLE   = 2'd2;
    localparam logic [1:0] MODE_LEVELS   = 2'd3;

    typedef struct packed {
        logic [3:0]  func;
        logic [2:0]  column;
        logic [15:0] row_bits;
    } item_t;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] cursor_column;
        logic [3:0] cursor_row;
        logic       cursor_closed;
        logic       redraw;
    } result_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic fetch;
    } cmd_t;

    typedef struct packed {
        logic seek;
        logic scan_done;
    } status_t;

endpackage

### hw/rtl/smcs_ctrl.sv
module smcs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  smcs_pkg::status_t status,
    output smcs_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done
);
    import smcs_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FETCH = 2'd2;
    localparam logic [1:0] ST_RESP  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        done       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.seek ? ST_SCAN : ST_FETCH;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### hw/rtl/smcs_datapath.sv
module smcs_datapath #(
    parameter int COLUMNS = smcs_pkg::COLUMNS_DEF,
    parameter int ROWS    = smcs_pkg::ROWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  smcs_pkg::item_t   item,
    input  smcs_pkg::cmd_t    cmd,
    input  logic              beat_limit_we,
    input  logic [7:0]        beat_limit_data,
    output smcs_pkg::status_t status,
    output smcs_pkg::result_t result
);
    import smcs_pkg::*;

    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);
    localparam int K_W   = $clog2(COLUMNS + 2);
    localparam int S_W   = $clog2(2 * COLUMNS + 1);

    logic [ROWS-1:0]  mem [COLUMNS];
    logic [COLUMNS-1:0] valid_reg;
    logic [ROWS-1:0]  rd_data_reg;
    logic             rd_ok_reg;

    logic [1:0]       mode_reg, mode_next;
    logic [COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [7:0]       beat_reg, beat_next;
    logic [7:0]       limit_reg;
    logic             redraw_reg, redraw_next;
    logic [K_W-1:0]   scan_k_reg, scan_k_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [K_W-1:0]   chk_k_reg, chk_k_next;
    logic [COL_W-1:0] chk_col_reg, chk_col_next;

    logic [7:0]       beat_inc;
    logic             tick_adv;
    logic             col_ok;
    logic [COL_W-1:0] wr_addr;
    logic             mem_we;
    logic             rd_en;
    logic [COL_W-1:0] rd_addr;
    logic             issue_ok;
    logic [S_W-1:0]   issue_sum;
    logic [COL_W-1:0] issue_addr;
    logic [ROWS-1:0]  word;
    logic [ROWS-1:0]  le_mask;
    logic [ROWS-1:0]  masked;
    logic             chk_first;
    logic             chk_last;
    logic             hit;
    logic [ROW_W-1:0] hit_row;
    logic             scan_done;

    assign beat_inc = beat_reg + 8'd1;
    assign tick_adv = (item.func == FUNC_TICK) && (mode_reg == MODE_LEVELS)
                      && (beat_inc > limit_reg);
    assign col_ok   = (int'(item.column) < COLUMNS);
    assign wr_addr  = COL_W'(item.column);
    assign mem_we   = cmd.load && (item.func == FUNC_WRITE_COL) && col_ok;

    assign issue_ok   = (scan_k_reg <= K_W'(COLUMNS));
    assign issue_sum  = S_W'(cur_col_reg) + S_W'(scan_k_reg);
    assign issue_addr = (issue_sum >= S_W'(COLUMNS)) ? COL_W'(issue_sum - S_W'(COLUMNS))
                                                      : COL_W'(issue_sum);
    assign rd_en      = (cmd.scan && issue_ok) || cmd.fetch;
    assign rd_addr    = cmd.fetch ? cur_col_reg : issue_addr;

    assign word      = rd_ok_reg ? rd_data_reg : '0;
    assign chk_first = (chk_k_reg == '0);
    assign chk_last  = (chk_k_reg == K_W'(COLUMNS));

    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            le_mask[i] = (i <= int'(cur_row_reg));
        end
    end

    always_comb
    begin
        if (chk_first)
        begin
            masked = word & ~le_mask;
        end
        else if (chk_last)
        begin
            masked = word & le_mask;
        end
        else
        begin
            masked = word;
        end
    end

    always_comb
    begin
        hit_row = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                hit_row = ROW_W'(i);
            end
        end
    end

    assign hit       = |masked;
    assign scan_done = cmd.scan && chk_valid_reg && (hit || chk_last);

    assign status.seek      = tick_adv || (item.func == FUNC_OPEN_LEVELS);
    assign status.scan_done = scan_done;

    always_comb
    begin
        mode_next      = mode_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        beat_next      = beat_reg;
        redraw_next    = redraw_reg;
        scan_k_next    = scan_k_reg;
        chk_valid_next = cmd.scan && issue_ok;
        chk_k_next     = scan_k_reg;
        chk_col_next   = issue_addr;

        if (cmd.load)
        begin
            redraw_next = 1'b0;
            scan_k_next = '0;
            case (item.func)
                FUNC_TICK:
                begin
                    if (mode_reg == MODE_LEVELS)
                    begin
                        if (tick_adv)
                        begin
                            beat_next   = '0;
                            redraw_next = 1'b1;
                        end
                        else
                        begin
                            beat_next = beat_inc;
                        end
                    end
                end
                FUNC_OPEN_SHOW:
                begin
                    mode_next = MODE_VIEW;
                end
                FUNC_OPEN_SINGLE:
                begin
                    mode_next    = MODE_SINGLE;
                    cur_col_next = '0;
                    cur_row_next = '0;
                end
                FUNC_OPEN_LEVELS:
                begin
                    mode_next    = MODE_LEVELS;
                    beat_next    = '0;
                    cur_col_next = '0;
                    cur_row_next = '0;
                end
                FUNC_UP:
                begin
                    if (cur_col_reg == '0)
                    begin
                        cur_col_next = COL_W'(COLUMNS - 1);
                        cur_row_next = (cur_row_reg == '0) ? ROW_W'(ROWS - 1)
                                                           : cur_row_reg - ROW_W'(1);
                    end
                    else
                    begin
                        cur_col_next = cur_col_reg - COL_W'(1);
                    end
                end
                FUNC_DOWN:
                begin
                    if (cur_col_reg == COL_W'(COLUMNS - 1))
                    begin
                        cur_col_next = '0;
                        cur_row_next = (cur_row_reg == ROW_W'(ROWS - 1)) ? '0
                                                           : cur_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        cur_col_next = cur_col_reg + COL_W'(1);
                    end
                end
                FUNC_ENTER:
                begin
                    cur_row_next = (cur_row_reg == ROW_W'(ROWS - 1)) ? '0
                                                       : cur_row_reg + ROW_W'(1);
                end
                FUNC_EXIT:
                begin
                    mode_next = MODE_INACTIVE;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.scan && issue_ok)
        begin
            scan_k_next = scan_k_reg + K_W'(1);
        end

        if (scan_done)
        begin
            if (hit)
            begin
                cur_col_next = chk_col_reg;
                cur_row_next = hit_row;
            end
            else
            begin
                cur_col_next = '0;
                cur_row_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= ROWS'(item.row_bits);
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            rd_ok_reg     <= 1'b0;
            mode_reg      <= MODE_INACTIVE;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            beat_reg      <= '0;
            limit_reg     <= BEAT_LIMIT_RESET;
            redraw_reg    <= 1'b0;
            scan_k_reg    <= '0;
            chk_valid_reg <= 1'b0;
            chk_k_reg     <= '0;
            chk_col_reg   <= '0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= valid_reg[rd_addr];
            end
            if (beat_limit_we)
            begin
                limit_reg <= beat_limit_data;
            end
            mode_reg      <= mode_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            beat_reg      <= beat_next;
            redraw_reg    <= redraw_next;
            scan_k_reg    <= scan_k_next;
            chk_valid_reg <= chk_valid_next;
            chk_k_reg     <= chk_k_next;
            chk_col_reg   <= chk_col_next;
        end
    end

    assign result.mode          = mode_reg;
    assign result.cursor_column = 3'(cur_col_reg);
    assign result.cursor_row    = 4'(cur_row_reg);
    assign result.cursor_closed = word[cur_row_reg];
    assign result.redraw        = redraw_reg;

endmodule

### hw/rtl/switch_matrix_cursor_scanner_top.sv
// Switch-matrix test cursor with column-major search for the next closed switch.
// An item is presented on item together with start and is accepted at a rising
// edge where start is high and busy is low. Each accepted item produces exactly
// one result on result, valid for the single cycle in which done is high; the
// receiver must take it then, as there is no back-pressure.
// The beat limit register is to be written through beat_limit_we and
// beat_limit_data only while the block is idle; the block does not enforce this.
// Items that do not move the cursor by search go through the fetch and response
// states; the result shows in the response state, and busy drops after it.
// A tick that advances the beat, and open-levels, run a search that reads one
// column word per cycle from the switch memory through its single read port,
// at most COLUMNS + 1 reads, with the read data registered before it is checked.
// Reset clears the switch matrix, the mode, the cursor and the beat count, and
// sets the beat limit to 48.
module switch_matrix_cursor_scanner_top #(
    parameter int COLUMNS = smcs_pkg::COLUMNS_DEF,
    parameter int ROWS    = smcs_pkg::ROWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  smcs_pkg::item_t   item,
    output logic              busy,
    output logic              done,
    output smcs_pkg::result_t result,
    input  logic              beat_limit_we,
    input  logic [7:0]        beat_limit_data
);
    import smcs_pkg::*;

    cmd_t    cmd;
    status_t status;

    smcs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    smcs_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item),
        .cmd             (cmd),
        .beat_limit_we   (beat_limit_we),
        .beat_limit_data (beat_limit_data),
        .status          (status),
        .result          (result)
    );

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done raised while idle");

    a_accept_no_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !done)
        else $error("result in the cycle right after acceptance");

    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy held after the result");

    a_redraw_levels: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.redraw) |-> (result.mode == MODE_LEVELS))
        else $error("redraw outside levels mode");
`endif

endmodule
